FILE: src/werm_pkg.sv
`timescale 1ns / 1ps
package werm_pkg;
  localparam logic [1:0] OP_EVENT      = 2'd0;
  localparam logic [1:0] OP_QUERY      = 2'd1;
  localparam logic [1:0] OP_HALT_FADE  = 2'd2;
  localparam logic [1:0] OP_HALT_CUT   = 2'd3;
  localparam logic       CFG_TIMEOUT   = 1'b0;
  localparam logic       CFG_FADE      = 1'b1;
  localparam int         CFG_IDX_W     = 2;
  localparam logic [8:0] LEVEL_FULL    = 9'd256;
  localparam logic [31:0] SPAN_DEFAULT = 32'd1000;
endpackage

FILE: src/werm_if.sv
`timescale 1ns / 1ps
interface werm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic signed [15:0] event_distance;
  modport source (output valid, op, now_ms, event_distance, input ready);
  modport sink   (input valid, op, now_ms, event_distance, output ready);
endinterface

interface werm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_rate;
  logic signed [31:0] distance_rate;
  logic signed [15:0] last_distance;
  logic [8:0]  fade_level;
  logic [31:0] total_events;
  logic signed [39:0] total_distance;
  modport source (output valid, event_rate, distance_rate, last_distance, fade_level,
                  total_events, total_distance, input ready);
  modport sink   (input valid, event_rate, distance_rate, last_distance, fade_level,
                  total_events, total_distance, output ready);
endinterface

interface werm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/windowed_event_rate_meter.sv
`timescale 1ns / 1ps
// Windowed event rate meter. Each item (op, now_ms, event_distance) yields one
// result, and the block takes no new item until that result has been taken.
// A single shift-subtract divider, one quotient bit per cycle, sets the timing.
// An event item sums the held distances (1..WINDOW after the event) one entry
// a cycle, then runs two divides (event rate and distance rate). A query or
// halt skips the sum and the rate divides; it runs a divide only when the fade
// level needs one (idle past timeout_ms, still inside fade_ms). Output stalls
// hold the result and delay the next item.
module windowed_event_rate_meter #(
  parameter int WINDOW = 8
) (
  input  logic clk,
  input  logic rst_n,
  werm_in_if.sink    in_ch,
  werm_out_if.source out_ch,
  werm_cfg_if.sink   cfg_ch
);
  import werm_pkg::*;

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
  localparam logic [63:0] ER_NUM = 64'(WINDOW) * 64'd65536000;

  localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_ERD = 4'd2, S_ERW = 4'd3,
                         S_DRD = 4'd4, S_DRW = 4'd5, S_FADE = 4'd6, S_FDW = 4'd7,
                         S_MUL = 4'd8, S_OUT = 4'd9;

  logic [3:0] st_r;
  logic [15:0] timeout_r, fade_r;
  logic [31:0] times_r [WINDOW];
  logic signed [15:0] dists_r [WINDOW];
  logic [IW-1:0] newest_r;
  logic [CW-1:0] held_r;
  logic [31:0] last_t_r, raw_er_r;
  logic signed [31:0] raw_dr_r;
  logic [31:0] tot_ev_r;
  logic [39:0] tot_d_r;
  logic [31:0] now_r, span_r;
  logic signed [24:0] sum_r;
  logic [CW-1:0] sidx_r;
  logic [8:0] level_r;
  logic [31:0] o_er_r, o_dr_r;

  logic        div_start, div_busy;
  logic [63:0] div_a, div_q;
  logic [31:0] div_b;
  werm_div u_div (.clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
                  .busy(div_busy), .quotient(div_q));

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.event_rate     = o_er_r;
  assign out_ch.distance_rate  = o_dr_r;
  assign out_ch.last_distance  = (held_r != '0) ? dists_r[newest_r] : 16'sd0;
  assign out_ch.fade_level     = level_r;
  assign out_ch.total_events   = tot_ev_r;
  assign out_ch.total_distance = tot_d_r;

  // fade terms
  logic [31:0] idle, dlt;
  logic [31:0] targ;
  logic [24:0] sum_mag;
  logic [32:0] fade_left;
  assign idle    = now_r - last_t_r;
  assign dlt     = idle - {16'd0, timeout_r};
  assign sum_mag = sum_r[24] ? 25'(-sum_r) : 25'(sum_r);
  assign fade_left = {17'd0, fade_r} - {1'b0, dlt};

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a = ER_NUM;
    div_b = span_r;
    case (st_r)
      S_ERD: div_start = 1'b1;
      S_DRD: begin
        div_start = 1'b1;
        div_a = 64'(sum_mag) * 64'd256000;
      end
      S_FADE: begin
        div_a = 64'({fade_left[15:0], 8'd0});
        div_b = {16'd0, fade_r};
        div_start = (idle > {16'd0, timeout_r}) && (fade_r != 16'd0)
                    && (dlt < {16'd0, fade_r});
      end
      default: ;
    endcase
  end

  // halt target
  assign targ = (in_ch.op == OP_HALT_FADE) ? {16'd0, timeout_r}
                : {16'd0, timeout_r} + {16'd0, fade_r};

  logic [40:0] mer;
  logic [40:0] mdr;
  logic [31:0] dr_mag;
  assign dr_mag = raw_dr_r[31] ? 32'(-raw_dr_r) : 32'(raw_dr_r);
  assign mer = ({9'd0, raw_er_r} * {32'd0, level_r}) >> 8;
  assign mdr = ({9'd0, dr_mag} * {32'd0, level_r}) >> 8;

  // oldest held slot: the slot after newest when full, else slot 0
  logic [IW-1:0] oldest;
  logic [IW-1:0] nidx;
  assign nidx = (newest_r == LAST_IDX) ? '0 : newest_r + IW'(1);
  assign oldest = (held_r == CW'(WINDOW)) ? nidx : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      timeout_r <= 16'd1000;
      fade_r    <= 16'd500;
      newest_r  <= LAST_IDX;
      held_r    <= '0;
      last_t_r  <= '0;
      raw_er_r  <= '0;
      raw_dr_r  <= '0;
      tot_ev_r  <= '0;
      tot_d_r   <= '0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == {1'b0, CFG_TIMEOUT}) timeout_r <= cfg_ch.data;
        if (cfg_ch.index == {1'b0, CFG_FADE})    fade_r    <= cfg_ch.data;
      end
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          now_r <= in_ch.now_ms;
          case (in_ch.op)
            OP_EVENT: begin
              tot_ev_r <= tot_ev_r + 32'd1;
              tot_d_r  <= tot_d_r + 40'(in_ch.event_distance);
              newest_r <= nidx;
              last_t_r <= in_ch.now_ms;
              times_r[nidx] <= in_ch.now_ms;
              dists_r[nidx] <= in_ch.event_distance;
              if (held_r != CW'(WINDOW)) held_r <= held_r + CW'(1);
              sum_r  <= '0;
              sidx_r <= '0;
              st_r   <= S_SUM;
            end
            OP_QUERY: st_r <= S_FADE;
            default: begin
              newest_r <= LAST_IDX;
              held_r   <= '0;
              if ((in_ch.now_ms - last_t_r) < targ) last_t_r <= in_ch.now_ms - targ;
              if (in_ch.op == OP_HALT_CUT) begin
                raw_er_r <= '0;
                raw_dr_r <= '0;
              end
              st_r <= S_FADE;
            end
          endcase
        end
        // window sum over slots 0..held-1, plus span
        S_SUM: begin
          if (sidx_r == held_r) begin
            span_r <= SPAN_DEFAULT;
            if (held_r >= CW'(2)) begin
              if (times_r[newest_r] != times_r[oldest])
                span_r <= times_r[newest_r] - times_r[oldest];
            end
            st_r <= S_ERD;
          end else begin
            sum_r  <= sum_r + 25'(dists_r[sidx_r[IW-1:0]]);
            sidx_r <= sidx_r + CW'(1);
          end
        end
        S_ERD: st_r <= S_ERW;
        S_ERW: if (!div_busy) begin
          raw_er_r <= (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
          st_r <= S_DRD;
        end
        S_DRD: st_r <= S_DRW;
        S_DRW: if (!div_busy) begin
          if (sum_r[24])
            raw_dr_r <= (div_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-div_q[31:0]);
          else
            raw_dr_r <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
          st_r <= S_FADE;
        end
        S_FADE: begin
          if (idle <= {16'd0, timeout_r}) begin
            level_r <= LEVEL_FULL;
            st_r <= S_MUL;
          end else begin
            held_r   <= '0;
            newest_r <= LAST_IDX;
            level_r  <= 9'd0;
            st_r <= div_start ? S_FDW : S_MUL;
          end
        end
        S_FDW: if (!div_busy) begin
          level_r <= div_q[8:0];
          st_r <= S_MUL;
        end
        S_MUL: begin
          o_er_r <= mer[31:0];
          o_dr_r <= raw_dr_r[31] ? 32'(-mdr[31:0]) : mdr[31:0];
          st_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/werm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. 64-bit dividend, 32-bit divisor.
module werm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  logic [63:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  assign busy     = (cnt_r != 7'd0);
  assign quotient = quo_r;

  // one shift-subtract step
  always_comb begin
    trial   = {rem_r[31:0], quo_r[63]};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (busy) begin
      cnt_nxt = cnt_r - 7'd1;
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else if (start) begin
      cnt_r <= 7'd64;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (start) begin
      quo_r <= dividend;
      rem_r <= 33'd0;
      dvs_r <= divisor;
    end else begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end
endmodule
